>>> src/tgmis_pkg.sv
// Package for the two-group multiplexed input scanner.
// Holds shared widths, register indexes, the result record and the counter helper.
// No dependencies.
`default_nettype none

package tgmis_pkg;

  // Default group size and fixed field widths.
  localparam int unsigned ChannelsPerGroupDefault = 4;
  localparam int unsigned ElapsedWidth            = 17;
  localparam int unsigned RegWidth                = 16;
  localparam int unsigned PtrWidth                = 4;
  localparam int unsigned StateBits               = 8;
  localparam int unsigned CfgIndexWidth           = 2;
  localparam int unsigned OutDataWidth            = 32;
  localparam int unsigned InDataWidth             = 8;

  localparam logic [ElapsedWidth-1:0] ElapsedMax = '1;
  localparam logic [StateBits-1:0]    QualMask   = 8'h0E;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] CfgGroupAPeriod = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CfgGroupBPeriod = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CfgSettleDelay  = 2'd2;

  // Register reset values.
  localparam logic [RegWidth-1:0] GroupAPeriodReset = 16'd1000;
  localparam logic [RegWidth-1:0] GroupBPeriodReset = 16'd200;
  localparam logic [RegWidth-1:0] SettleDelayReset  = 16'd5;

  // One result record, produced for every tick.
  typedef struct packed {
    logic [StateBits-1:0] qualified_inputs;
    logic                 level_changed;
    logic [2:0]           sampled_channel;
    logic                 sampled_now;
    logic [StateBits-1:0] input_states;
    logic [PtrWidth-1:0]  channel_select;
    logic                 mux_enable;
  } result_t;

  // Saturating increment of an elapsed counter.
  function automatic logic [ElapsedWidth-1:0] sat_inc(logic [ElapsedWidth-1:0] v);
    return (v == ElapsedMax) ? v : v + {{(ElapsedWidth-1){1'b0}}, 1'b1};
  endfunction

endpackage

`default_nettype wire

>>> src/tgmis_core.sv
// Scanner state and the per-tick update logic.
// Holds the configuration registers, counters, group flags and the state byte.
// Depends on tgmis_pkg.
`default_nettype none

module tgmis_core import tgmis_pkg::*; #(
  parameter int unsigned CHANNELS_PER_GROUP = ChannelsPerGroupDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CfgIndexWidth-1:0] cfg_index_i,
  input  wire logic [RegWidth-1:0]      cfg_data_i,
  input  wire logic                     step_i,
  input  wire logic                     level_i,
  output result_t                       result_o
);

  localparam logic [PtrWidth:0]   EndA   = (PtrWidth+1)'(CHANNELS_PER_GROUP);
  localparam logic [PtrWidth:0]   EndB   = (PtrWidth+1)'(2 * CHANNELS_PER_GROUP);
  localparam logic [PtrWidth-1:0] FirstB = PtrWidth'(CHANNELS_PER_GROUP);

  logic [RegWidth-1:0]     period_a_q, period_b_q, settle_q;
  logic [ElapsedWidth-1:0] elapsed_a_q, elapsed_b_q, elapsed_s_q;
  logic [ElapsedWidth-1:0] elapsed_a_d, elapsed_b_d, elapsed_s_d;
  logic                    scan_a_q, scan_b_q, scan_a_d, scan_b_d;
  logic                    enable_q, enable_d;
  logic [PtrWidth-1:0]     ptr_q, ptr_d, sel_q, sel_d;
  logic [StateBits-1:0]    state_q, state_d;
  logic                    smp_now, smp_chg;
  logic [2:0]              smp_chan;
  logic [PtrWidth:0]       ptr_next, group_end;
  logic                    settled;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_a_q <= GroupAPeriodReset;
      period_b_q <= GroupBPeriodReset;
      settle_q   <= SettleDelayReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgGroupAPeriod: period_a_q <= cfg_data_i;
        CfgGroupBPeriod: period_b_q <= cfg_data_i;
        CfgSettleDelay:  settle_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // One tick: advance counters, check starts, then take at most one sample.
  // The two groups never scan together, so one sampling path serves both.
  always_comb begin
    elapsed_a_d = sat_inc(elapsed_a_q);
    elapsed_b_d = sat_inc(elapsed_b_q);
    elapsed_s_d = sat_inc(elapsed_s_q);
    scan_a_d    = scan_a_q;
    scan_b_d    = scan_b_q;
    enable_d    = enable_q;
    ptr_d       = ptr_q;
    sel_d       = sel_q;
    state_d     = state_q;
    smp_now     = 1'b0;
    smp_chan    = '0;
    smp_chg     = 1'b0;
    ptr_next    = '0;
    group_end   = EndA;

    settled = elapsed_s_d > {1'b0, settle_q};
    if (!scan_b_q && (elapsed_a_d > {1'b0, period_a_q}) && settled) begin
      scan_a_d    = 1'b1;
      elapsed_a_d = '0;
      elapsed_s_d = '0;
      ptr_d       = '0;
      enable_d    = 1'b1;
      sel_d       = '0;
    end

    settled = elapsed_s_d > {1'b0, settle_q};
    if (!scan_a_d && (elapsed_b_d > {1'b0, period_b_q}) && settled) begin
      scan_b_d    = 1'b1;
      elapsed_b_d = '0;
      elapsed_s_d = '0;
      ptr_d       = FirstB;
      enable_d    = 1'b1;
      sel_d       = FirstB;
    end

    settled = elapsed_s_d > {1'b0, settle_q};
    if ((scan_a_d || scan_b_d) && settled) begin
      group_end = scan_a_d ? EndA : EndB;
      // Channels 8 and up advance but store nothing.
      if (!ptr_d[PtrWidth-1]) begin
        smp_now  = 1'b1;
        smp_chan = ptr_d[2:0];
        smp_chg  = state_q[ptr_d[2:0]] != level_i;
        state_d[ptr_d[2:0]] = level_i;
      end
      ptr_next    = {1'b0, ptr_d} + {{PtrWidth{1'b0}}, 1'b1};
      ptr_d       = ptr_next[PtrWidth-1:0];
      elapsed_s_d = '0;
      if (ptr_next == group_end) begin
        enable_d = 1'b0;
        if (scan_a_d) begin
          scan_a_d = 1'b0;
        end else begin
          scan_b_d = 1'b0;
        end
      end else begin
        sel_d = ptr_next[PtrWidth-1:0];
      end
    end
  end

  // State advances once per accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_a_q <= '0;
      elapsed_b_q <= '0;
      elapsed_s_q <= '0;
      scan_a_q    <= 1'b0;
      scan_b_q    <= 1'b0;
      enable_q    <= 1'b0;
      ptr_q       <= '0;
      sel_q       <= '0;
      state_q     <= '0;
    end else if (step_i) begin
      elapsed_a_q <= elapsed_a_d;
      elapsed_b_q <= elapsed_b_d;
      elapsed_s_q <= elapsed_s_d;
      scan_a_q    <= scan_a_d;
      scan_b_q    <= scan_b_d;
      enable_q    <= enable_d;
      ptr_q       <= ptr_d;
      sel_q       <= sel_d;
      state_q     <= state_d;
    end
  end

  // Result of the tick, taken into the output register by the top level.
  always_comb begin
    result_o.mux_enable       = enable_d;
    result_o.channel_select   = sel_d;
    result_o.input_states     = state_d;
    result_o.sampled_now      = smp_now;
    result_o.sampled_channel  = smp_chan;
    result_o.level_changed    = smp_chg;
    result_o.qualified_inputs = state_d & QualMask;
  end

endmodule

`default_nettype wire

>>> src/two_group_mux_input_scanner.sv
// Top level of the two-group multiplexed input scanner.
// Input register, scanner core and output register. Depends on tgmis_pkg, tgmis_core.
//
// Channel   Direction  Width  Contents
// s_axis    in         8      one millisecond tick with the signal level
// m_axis    out        32     multiplexer control, state byte and sample report
// cfg       in         16     group A period, group B period, settle delay
//
// Each tick is held in the input register; when it moves on, the core updates its
// state and the output register takes the result. One tick is accepted per cycle
// when the output is not stalled, as the scanner state is updated once per tick.
// Reset restores the register defaults and clears all scanner state at once.
// A stall on m_axis holds the result and backs up through the input register.
`default_nettype none

module two_group_mux_input_scanner import tgmis_pkg::*; #(
  parameter int unsigned CHANNELS_PER_GROUP = ChannelsPerGroupDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid,
  output      logic                     s_axis_tready,
  // [0] signal_level, [7:1] zero
  input  wire logic [InDataWidth-1:0]   s_axis_tdata,
  output      logic                     m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // [0] mux_enable, [4:1] channel_select, [12:5] input_states, [13] sampled_now,
  // [16:14] sampled_channel, [17] level_changed, [25:18] qualified_inputs,
  // [31:26] zero
  output      logic [OutDataWidth-1:0]  m_axis_tdata,
  input  wire logic                     cfg_we_i,
  input  wire logic [CfgIndexWidth-1:0] cfg_index_i,
  input  wire logic [RegWidth-1:0]      cfg_data_i
);

  localparam int unsigned ResultWidth = $bits(result_t);

  logic    in_valid_q, level_q;
  logic    out_valid_q;
  result_t out_q, result;
  logic    step;

  // A held tick moves on when the output register is free or being drained.
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      level_q <= s_axis_tdata[0];
    end
  end

  tgmis_core #(
    .CHANNELS_PER_GROUP (CHANNELS_PER_GROUP)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .level_i     (level_q),
    .result_o    (result)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataWidth-ResultWidth){1'b0}}, out_q};

endmodule

`default_nettype wire

>>> src/tgmis_checker.sv
// Port-level checks for the two-group multiplexed input scanner.
// Bound to the top level. Depends on tgmis_pkg.
`default_nettype none

module tgmis_checker import tgmis_pkg::*; (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     m_axis_tvalid,
  input wire logic                     m_axis_tready,
  input wire logic [OutDataWidth-1:0]  m_axis_tdata
);

  // A stalled result holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // The qualified inputs mirror bits one to three of the state byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[25:18] == (m_axis_tdata[12:5] & QualMask))
    else $error("qualified inputs do not match state byte");

  // Without a sample the channel and change fields stay zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[13] |-> m_axis_tdata[17:14] == 4'd0)
    else $error("sample report without a sample");

  // The padding bits above the result stay zero in the next result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid || m_axis_tdata[31:26] == 6'd0)
    else $error("padding bits set");

endmodule

bind two_group_mux_input_scanner tgmis_checker u_tgmis_checker (.*);

`default_nettype wire
